// ===== rtl/core/pbd_pkg.sv =====
package pbd_pkg;

   typedef struct packed {
      logic signed [15:0] offset_cx;
      logic signed [15:0] offset_cy;
      logic signed [15:0] offset_w;
      logic signed [15:0] offset_h;
      logic signed [15:0] prior_xmin;
      logic signed [15:0] prior_ymin;
      logic signed [15:0] prior_xmax;
      logic signed [15:0] prior_ymax;
      logic               last_box;
   } req_type;

   typedef struct packed {
      logic signed [15:0] box_left;
      logic signed [15:0] box_top;
      logic signed [15:0] box_right;
      logic signed [15:0] box_bottom;
      logic               last_out;
   } rsp_type;

   typedef enum logic [1:0] {
      CSR_VAR_CX = 2'd0,
      CSR_VAR_CY = 2'd1,
      CSR_VAR_W  = 2'd2,
      CSR_VAR_H  = 2'd3
   } csr_index_type;

   localparam logic [15:0] VAR_CX_RESET = 16'd3277;
   localparam logic [15:0] VAR_CY_RESET = 16'd3277;
   localparam logic [15:0] VAR_W_RESET  = 16'd6554;
   localparam logic [15:0] VAR_H_RESET  = 16'd6554;

   // log2(e) in Q.24, ln(2) in Q.16
   localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
   localparam logic [15:0] LN2_Q16   = 16'd45426;
   localparam logic [16:0] ONE_Q16   = 17'd65536;
   // floor(x/6) == (x*43)>>8 for the cubic term range (x <= 43)
   localparam logic [10:0] RECIP6_Q8 = 11'd43;

   // round(2^(i/8) * 2^16)
   function automatic logic [16:0] exp2_eighth(input logic [2:0] i);
      logic [16:0] v;
      case (i)
         3'd0:    v = 17'd65536;
         3'd1:    v = 17'd71468;
         3'd2:    v = 17'd77936;
         3'd3:    v = 17'd84990;
         3'd4:    v = 17'd92682;
         3'd5:    v = 17'd101070;
         3'd6:    v = 17'd110218;
         default: v = 17'd120194;
      endcase
      return v;
   endfunction

   // Q.15 -> Q.14, round half up, saturate
   function automatic logic signed [15:0] sat_q14(input logic signed [46:0] x);
      logic signed [46:0] r;
      logic signed [15:0] v;
      r = (x + 47'sd1) >>> 1;
      if (r > 47'sd32767) begin
         v = 16'sh7fff;
      end else if (r < -47'sd32768) begin
         v = -16'sh8000;
      end else begin
         v = r[15:0];
      end
      return v;
   endfunction

endpackage

// ===== rtl/core/prior_box_decode_top.sv =====
// SSD center-size box decoder: one box accepted per clock on start, never busy, and
// its decoded corners appear on rsp_data with rsp_strobe at the end of a 9-stage
// pipeline (variance scaling, log2(e) scaling, the ln2 polynomial terms, the 2^(i/8)
// table, the size product, then the exponent shift and corner rounding). Results are
// not held: the receiver must take each one in its strobe cycle. Write variance
// registers only while idle.
module prior_box_decode_top
   import pbd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_data,
   output logic          rsp_strobe,
   output rsp_type       rsp_data,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata
);

   logic [15:0] var_cx_ff, var_cy_ff, var_w_ff, var_h_ff;
   logic [15:0] var_cx_in, var_cy_in, var_w_in, var_h_in;

   logic [9:1] valid_ff, valid_in;
   logic [9:1] last_ff, last_in;

   // stage 1
   logic signed [17:0] d1_ff [2], d1_in [2];
   logic signed [16:0] cc1_ff [2], cc1_in [2];
   logic signed [32:0] ac1_ff [2], ac1_in [2];
   logic signed [32:0] as1_ff [2], as1_in [2];
   // stage 2
   logic signed [17:0] d2_ff [2], d2_in [2];
   logic signed [16:0] cc2_ff [2], cc2_in [2];
   logic signed [46:0] tm2_ff [2], tm2_in [2];
   logic signed [50:0] pc2_ff [2], pc2_in [2];
   // stage 3
   logic signed [17:0] d3_ff [2], d3_in [2];
   logic signed [24:0] ctr3_ff [2], ctr3_in [2];
   logic signed [6:0]  k3_ff [2], k3_in [2];
   logic [2:0]         idx3_ff [2], idx3_in [2];
   logic [12:0]        uu3_ff [2], uu3_in [2];
   // stage 4
   logic signed [17:0] d4_ff [2];
   logic signed [24:0] ctr4_ff [2];
   logic signed [6:0]  k4_ff [2];
   logic [2:0]         idx4_ff [2];
   logic [12:0]        uu4_ff [2];
   logic [8:0]         sq4_ff [2], sq4_in [2];
   // stage 5
   logic signed [17:0] d5_ff [2];
   logic signed [24:0] ctr5_ff [2];
   logic signed [6:0]  k5_ff [2];
   logic [2:0]         idx5_ff [2];
   logic [12:0]        uu5_ff [2];
   logic [8:0]         sq5_ff [2];
   logic [5:0]         cb5_ff [2], cb5_in [2];
   // stage 6
   logic signed [17:0] d6_ff [2];
   logic signed [24:0] ctr6_ff [2];
   logic signed [6:0]  k6_ff [2];
   logic [17:0]        mm6_ff [2], mm6_in [2];
   // stage 7
   logic signed [24:0] ctr7_ff [2];
   logic signed [6:0]  k7_ff [2];
   logic signed [36:0] prod7_ff [2], prod7_in [2];
   // stage 8
   logic signed [24:0] ctr8_ff [2];
   logic signed [45:0] half8_ff [2], half8_in [2];
   // stage 9
   rsp_type rsp_ff, rsp_in;

   // combinational temporaries
   logic signed [15:0] lo_w [2], hi_w [2], oc_w [2], os_w [2];
   logic [15:0]        vc_w [2], vs_w [2];
   logic signed [32:0] ts_w [2];
   logic signed [20:0] t_w [2];
   logic signed [46:0] yw_w [2];
   logic [29:0]        up_w [2];
   logic signed [50:0] cr_w [2];
   logic [26:0]        sqp_w [2];
   logic [22:0]        cbp_w [2];
   logic [10:0]        c6_w [2];
   logic [16:0]        p_w [2];
   logic [33:0]        mp_w [2];
   logic signed [45:0] pw_w [2];
   logic [2:0]         lsh_w [2];
   logic [5:0]         rsh_w [2];
   logic signed [46:0] lo9_w [2], hi9_w [2];

   assign busy = 1'b0;

   always_comb begin
      var_cx_in = var_cx_ff;
      var_cy_in = var_cy_ff;
      var_w_in  = var_w_ff;
      var_h_in  = var_h_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_VAR_CX: var_cx_in = csr_wdata;
            CSR_VAR_CY: var_cy_in = csr_wdata;
            CSR_VAR_W:  var_w_in  = csr_wdata;
            CSR_VAR_H:  var_h_in  = csr_wdata;
         endcase
      end
   end

   assign valid_in = {valid_ff[8:1], start & ~busy};
   assign last_in  = {last_ff[8:1], req_data.last_box};

   always_comb begin
      lo_w[0] = req_data.prior_xmin;
      hi_w[0] = req_data.prior_xmax;
      oc_w[0] = req_data.offset_cx;
      os_w[0] = req_data.offset_w;
      vc_w[0] = var_cx_ff;
      vs_w[0] = var_w_ff;
      lo_w[1] = req_data.prior_ymin;
      hi_w[1] = req_data.prior_ymax;
      oc_w[1] = req_data.offset_cy;
      os_w[1] = req_data.offset_h;
      vc_w[1] = var_cy_ff;
      vs_w[1] = var_h_ff;

      for (int a = 0; a < 2; a++) begin
         // stage 1: size, doubled center, variance times offset
         d1_in[a]  = $signed({{2{hi_w[a][15]}}, hi_w[a]}) -
                     $signed({{2{lo_w[a][15]}}, lo_w[a]});
         cc1_in[a] = $signed({hi_w[a][15], hi_w[a]}) + $signed({lo_w[a][15], lo_w[a]});
         ac1_in[a] = $signed({1'b0, vc_w[a]}) * oc_w[a];
         as1_in[a] = $signed({1'b0, vs_w[a]}) * os_w[a];

         // stage 2: exponent argument to Q.16, scale by log2(e); center product
         ts_w[a]   = (as1_ff[a] + 33'sd1024) >>> 11;
         t_w[a]    = ts_w[a][20:0];
         tm2_in[a] = t_w[a] * $signed({1'b0, LOG2E_Q24});
         pc2_in[a] = ac1_ff[a] * d1_ff[a];
         d2_in[a]  = d1_ff[a];
         cc2_in[a] = cc1_ff[a];

         // stage 3: split log2 into integer and fraction, first polynomial term
         yw_w[a]    = (tm2_ff[a] + 47'sd8388608) >>> 24;
         k3_in[a]   = yw_w[a][22:16];
         idx3_in[a] = yw_w[a][15:13];
         up_w[a]    = 30'(yw_w[a][12:0]) * 30'(LN2_Q16) + 30'd32768;
         uu3_in[a]  = up_w[a][28:16];
         cr_w[a]    = (pc2_ff[a] + (51'sd1 <<< 25)) >>> 26;
         ctr3_in[a] = $signed({{8{cc2_ff[a][16]}}, cc2_ff[a]}) + cr_w[a][24:0];
         d3_in[a]   = d2_ff[a];

         // stage 4: square
         sqp_w[a]  = 27'(uu3_ff[a]) * 27'(uu3_ff[a]) + 27'd32768;
         sq4_in[a] = sqp_w[a][24:16];

         // stage 5: cube
         cbp_w[a]  = 23'(sq4_ff[a]) * 23'(uu4_ff[a]) + 23'd32768;
         cb5_in[a] = cbp_w[a][21:16];

         // stage 6: polynomial sum times 2^(i/8)
         c6_w[a]   = 11'(cb5_ff[a]) * RECIP6_Q8;
         p_w[a]    = ONE_Q16 + 17'(uu5_ff[a]) + 17'(sq5_ff[a][8:1]) + 17'(c6_w[a][10:8]);
         mp_w[a]   = 34'(exp2_eighth(idx5_ff[a])) * 34'(p_w[a]) + 34'd32768;
         mm6_in[a] = mp_w[a][33:16];

         // stage 7: size times mantissa
         prod7_in[a] = d6_ff[a] * $signed({1'b0, mm6_ff[a]});

         // stage 8: apply 2^(k-16), rounding on right shifts
         pw_w[a]  = prod7_ff[a];
         lsh_w[a] = 3'(k7_ff[a] - 7'sd16);
         rsh_w[a] = 6'(7'sd16 - k7_ff[a]);
         if (k7_ff[a] >= 7'sd16) begin
            half8_in[a] = pw_w[a] <<< lsh_w[a];
         end else begin
            half8_in[a] = (pw_w[a] + (46'sd1 <<< (rsh_w[a] - 6'd1))) >>> rsh_w[a];
         end

         // stage 9: corners
         lo9_w[a] = $signed({{22{ctr8_ff[a][24]}}, ctr8_ff[a]}) -
                    $signed({half8_ff[a][45], half8_ff[a]});
         hi9_w[a] = $signed({{22{ctr8_ff[a][24]}}, ctr8_ff[a]}) +
                    $signed({half8_ff[a][45], half8_ff[a]});
      end

      rsp_in.box_left   = sat_q14(lo9_w[0]);
      rsp_in.box_right  = sat_q14(hi9_w[0]);
      rsp_in.box_top    = sat_q14(lo9_w[1]);
      rsp_in.box_bottom = sat_q14(hi9_w[1]);
      rsp_in.last_out   = last_ff[8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         var_cx_ff <= VAR_CX_RESET;
         var_cy_ff <= VAR_CY_RESET;
         var_w_ff  <= VAR_W_RESET;
         var_h_ff  <= VAR_H_RESET;
      end else begin
         valid_ff  <= valid_in;
         var_cx_ff <= var_cx_in;
         var_cy_ff <= var_cy_in;
         var_w_ff  <= var_w_in;
         var_h_ff  <= var_h_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      rsp_ff  <= rsp_in;
      for (int a = 0; a < 2; a++) begin
         d1_ff[a]    <= d1_in[a];
         cc1_ff[a]   <= cc1_in[a];
         ac1_ff[a]   <= ac1_in[a];
         as1_ff[a]   <= as1_in[a];
         d2_ff[a]    <= d2_in[a];
         cc2_ff[a]   <= cc2_in[a];
         tm2_ff[a]   <= tm2_in[a];
         pc2_ff[a]   <= pc2_in[a];
         d3_ff[a]    <= d3_in[a];
         ctr3_ff[a]  <= ctr3_in[a];
         k3_ff[a]    <= k3_in[a];
         idx3_ff[a]  <= idx3_in[a];
         uu3_ff[a]   <= uu3_in[a];
         d4_ff[a]    <= d3_ff[a];
         ctr4_ff[a]  <= ctr3_ff[a];
         k4_ff[a]    <= k3_ff[a];
         idx4_ff[a]  <= idx3_ff[a];
         uu4_ff[a]   <= uu3_ff[a];
         sq4_ff[a]   <= sq4_in[a];
         d5_ff[a]    <= d4_ff[a];
         ctr5_ff[a]  <= ctr4_ff[a];
         k5_ff[a]    <= k4_ff[a];
         idx5_ff[a]  <= idx4_ff[a];
         uu5_ff[a]   <= uu4_ff[a];
         sq5_ff[a]   <= sq4_ff[a];
         cb5_ff[a]   <= cb5_in[a];
         d6_ff[a]    <= d5_ff[a];
         ctr6_ff[a]  <= ctr5_ff[a];
         k6_ff[a]    <= k5_ff[a];
         mm6_ff[a]   <= mm6_in[a];
         ctr7_ff[a]  <= ctr6_ff[a];
         k7_ff[a]    <= k6_ff[a];
         prod7_ff[a] <= prod7_in[a];
         ctr8_ff[a]  <= ctr7_ff[a];
         half8_ff[a] <= half8_in[a];
      end
   end

   assign rsp_strobe = valid_ff[9];
   assign rsp_data   = rsp_ff;

endmodule
